FILE: rtl/drec_pkg.sv
package drec_pkg;

    localparam int ChanCount  = 3;
    localparam int ValueW     = 12;
    localparam int PctW       = 7;
    localparam int MagW       = 11;
    localparam int SegIdxW    = 5;
    localparam int OffW       = 6;
    localparam int DeltaW     = 8;
    localparam int CfgIdxW    = 3;

    localparam int ValueLimit = 1250;
    localparam int Segments   = 25;
    localparam int SegWidth   = ValueLimit / Segments;
    localparam int PctFull    = 100;

    // floor(x / 50) == (x * 1311) >> 16 for x <= 1250
    localparam int SegRecip      = 1311;
    localparam int SegRecipShift = 16;
    // floor(x / 50) == (x * 5243) >> 18 for x <= 11400
    localparam int InterpRecip      = 5243;
    localparam int InterpRecipShift = 18;
    // floor(x / 100) == (x * 167773) >> 24 for x <= 125000
    localparam int PctRecip      = 167773;
    localparam int PctRecipShift = 24;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_EXPO_AILERON  = 3'd0,
        CFG_EXPO_ELEVATOR = 3'd1,
        CFG_EXPO_RUDDER   = 3'd2,
        CFG_RATE_AILERON  = 3'd3,
        CFG_RATE_ELEVATOR = 3'd4,
        CFG_RATE_RUDDER   = 3'd5
    } cfg_idx_t;

    // exponential curve breakpoints, one every SegWidth
    function automatic logic [MagW-1:0] curve_point(input logic [SegIdxW-1:0] idx);
        logic [MagW-1:0] pt;
        unique case (idx)
            5'd0:    pt = 11'd0;
            5'd1:    pt = 11'd2;
            5'd2:    pt = 11'd4;
            5'd3:    pt = 11'd7;
            5'd4:    pt = 11'd10;
            5'd5:    pt = 11'd14;
            5'd6:    pt = 11'd20;
            5'd7:    pt = 11'd26;
            5'd8:    pt = 11'd33;
            5'd9:    pt = 11'd43;
            5'd10:   pt = 11'd54;
            5'd11:   pt = 11'd68;
            5'd12:   pt = 11'd84;
            5'd13:   pt = 11'd106;
            5'd14:   pt = 11'd131;
            5'd15:   pt = 11'd162;
            5'd16:   pt = 11'd200;
            5'd17:   pt = 11'd246;
            5'd18:   pt = 11'd302;
            5'd19:   pt = 11'd370;
            5'd20:   pt = 11'd454;
            5'd21:   pt = 11'd557;
            5'd22:   pt = 11'd682;
            5'd23:   pt = 11'd835;
            5'd24:   pt = 11'd1022;
            5'd25:   pt = 11'd1250;
            default: pt = 11'd0;
        endcase
        return pt;
    endfunction

    function automatic logic [PctW-1:0] clamp_pct(input logic [PctW-1:0] p);
        return (p > PctW'(PctFull)) ? PctW'(PctFull) : p;
    endfunction

endpackage

FILE: rtl/dual_rate_expo_curve_unit.sv
// Shapes one frame of three stick values (aileron, elevator, rudder) per request: each value
// is limited to +-1250, run through a 25-segment interpolated expo curve blended with the
// linear value by its expo percent, and then scaled by its rate percent. The datapath is a
// nine-stage pipeline (limit, segment select, table lookup, interpolate multiply, /50,
// blend, /100, rate multiply, /100 with sign restore); it takes a new frame every cycle
// unless an output stall has backed the pipeline up to the input. Each stage holds its own
// valid bit and fills bubbles while the output is stalled. Percent registers above 100 act as
// 100, writes to unknown indexes are dropped. Write configuration only while the pipeline is empty.
module dual_rate_expo_curve_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [drec_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [drec_pkg::PctW-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [drec_pkg::ValueW-1:0]  s_aileron_in,
    input  logic signed [drec_pkg::ValueW-1:0]  s_elevator_in,
    input  logic signed [drec_pkg::ValueW-1:0]  s_rudder_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [drec_pkg::ValueW-1:0]  m_aileron_out,
    output logic signed [drec_pkg::ValueW-1:0]  m_elevator_out,
    output logic signed [drec_pkg::ValueW-1:0]  m_rudder_out
);
    import drec_pkg::*;

    localparam int Stages = 9;
    localparam int BlendW = 17;
    localparam int ProdW  = 14;

    logic [PctW-1:0] expo_reg [ChanCount];
    logic [PctW-1:0] rate_reg [ChanCount];

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] en;

    logic signed [ValueW-1:0] in_val [ChanCount];

    // stage registers per channel
    logic [MagW-1:0]    a_mag_reg   [ChanCount];
    logic [MagW-1:0]    b_mag_reg   [ChanCount];
    logic [SegIdxW-1:0] b_seg_reg   [ChanCount];
    logic [MagW-1:0]    c_mag_reg   [ChanCount];
    logic [OffW-1:0]    c_off_reg   [ChanCount];
    logic [MagW-1:0]    c_y0_reg    [ChanCount];
    logic [DeltaW-1:0]  c_dy_reg    [ChanCount];
    logic [MagW-1:0]    d_mag_reg   [ChanCount];
    logic [ProdW-1:0]   d_prod_reg  [ChanCount];
    logic [MagW-1:0]    d_y0_reg    [ChanCount];
    logic [MagW-1:0]    e_mag_reg   [ChanCount];
    logic [MagW-1:0]    e_curve_reg [ChanCount];
    logic [BlendW-1:0]  f_blend_reg [ChanCount];
    logic [MagW-1:0]    g_w_reg     [ChanCount];
    logic [BlendW-1:0]  h_t_reg     [ChanCount];
    logic [ValueW-1:0]  out_reg     [ChanCount];
    logic [Stages-2:0]  neg_reg     [ChanCount];

    logic [MagW-1:0]    a_mag_next   [ChanCount];
    logic [SegIdxW-1:0] b_seg_next   [ChanCount];
    logic [OffW-1:0]    c_off_next   [ChanCount];
    logic [MagW-1:0]    c_y0_next    [ChanCount];
    logic [DeltaW-1:0]  c_dy_next    [ChanCount];
    logic [ProdW-1:0]   d_prod_next  [ChanCount];
    logic [MagW-1:0]    e_curve_next [ChanCount];
    logic [BlendW-1:0]  f_blend_next [ChanCount];
    logic [MagW-1:0]    g_w_next     [ChanCount];
    logic [BlendW-1:0]  h_t_next     [ChanCount];
    logic [ValueW-1:0]  out_next     [ChanCount];

    assign in_val[0] = s_aileron_in;
    assign in_val[1] = s_elevator_in;
    assign in_val[2] = s_rudder_in;

    // a stage loads when it is empty or the next one loads
    always_comb begin
        en[Stages-1] = !vld_reg[Stages-1] || m_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[Stages-1];

    always_comb begin
        logic [ValueW-1:0]                 abs_val;
        logic [MagW+SegIdxW+4:0]           seg_prod;
        logic [SegIdxW-1:0]                seg_raw;
        logic [MagW-1:0]                   seg_base;
        logic [SegIdxW-1:0]                seg_nxt;
        logic [MagW-1:0]                   y1;
        logic [ProdW+InterpRecipShift-7:0] ip_prod;
        logic [PctW-1:0]                   pe;
        logic [PctW-1:0]                   pr;
        logic [BlendW+PctRecipShift-7:0]   f_prod;
        logic [BlendW+PctRecipShift-7:0]   h_prod;
        logic [MagW-1:0]                   q;
        for (int ch = 0; ch < ChanCount; ch++) begin
            abs_val = in_val[ch][ValueW-1] ? ValueW'(-in_val[ch]) : ValueW'(in_val[ch]);
            a_mag_next[ch] = (abs_val > ValueW'(ValueLimit)) ? MagW'(ValueLimit)
                                                              : abs_val[MagW-1:0];

            seg_prod = MagW'(a_mag_reg[ch]) * (MagW+SegIdxW+5)'(SegRecip);
            seg_raw  = seg_prod[SegRecipShift +: SegIdxW];
            b_seg_next[ch] = (seg_raw >= SegIdxW'(Segments)) ? SegIdxW'(Segments - 1) : seg_raw;

            seg_base = MagW'(b_seg_reg[ch]) * MagW'(SegWidth);
            seg_nxt  = b_seg_reg[ch] + SegIdxW'(1);
            y1       = curve_point(seg_nxt);
            c_off_next[ch] = OffW'(b_mag_reg[ch] - seg_base);
            c_y0_next[ch]  = curve_point(b_seg_reg[ch]);
            c_dy_next[ch]  = DeltaW'(y1 - c_y0_next[ch]);

            d_prod_next[ch] = ProdW'(c_off_reg[ch]) * ProdW'(c_dy_reg[ch]);

            ip_prod = (ProdW+InterpRecipShift-6)'(d_prod_reg[ch])
                    * (ProdW+InterpRecipShift-6)'(InterpRecip);
            e_curve_next[ch] = MagW'(ip_prod[ProdW+InterpRecipShift-7:InterpRecipShift])
                             + d_y0_reg[ch];

            pe = clamp_pct(expo_reg[ch]);
            f_blend_next[ch] = BlendW'(pe) * BlendW'(e_curve_reg[ch])
                             + BlendW'(PctW'(PctFull) - pe) * BlendW'(e_mag_reg[ch]);

            f_prod = (BlendW+PctRecipShift-6)'(f_blend_reg[ch])
                   * (BlendW+PctRecipShift-6)'(PctRecip);
            g_w_next[ch] = f_prod[PctRecipShift +: MagW];

            pr = clamp_pct(rate_reg[ch]);
            h_t_next[ch] = BlendW'(g_w_reg[ch]) * BlendW'(pr);

            // truncation toward zero: scale the magnitude, then restore the sign
            h_prod = (BlendW+PctRecipShift-6)'(h_t_reg[ch])
                   * (BlendW+PctRecipShift-6)'(PctRecip);
            q = h_prod[PctRecipShift +: MagW];
            out_next[ch] = neg_reg[ch][Stages-2] ? ValueW'(-{1'b0, q}) : {1'b0, q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int ch = 0; ch < ChanCount; ch++) begin
                expo_reg[ch] <= '0;
                rate_reg[ch] <= PctW'(PctFull);
            end
        end else begin
            for (int i = 0; i < Stages; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_EXPO_AILERON:  expo_reg[0] <= cfg_data;
                    CFG_EXPO_ELEVATOR: expo_reg[1] <= cfg_data;
                    CFG_EXPO_RUDDER:   expo_reg[2] <= cfg_data;
                    CFG_RATE_AILERON:  rate_reg[0] <= cfg_data;
                    CFG_RATE_ELEVATOR: rate_reg[1] <= cfg_data;
                    CFG_RATE_RUDDER:   rate_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < ChanCount; ch++) begin
            if (en[0]) begin
                a_mag_reg[ch]     <= a_mag_next[ch];
                neg_reg[ch][0]    <= in_val[ch][ValueW-1];
            end
            if (en[1]) begin
                b_mag_reg[ch]     <= a_mag_reg[ch];
                b_seg_reg[ch]     <= b_seg_next[ch];
            end
            if (en[2]) begin
                c_mag_reg[ch]     <= b_mag_reg[ch];
                c_off_reg[ch]     <= c_off_next[ch];
                c_y0_reg[ch]      <= c_y0_next[ch];
                c_dy_reg[ch]      <= c_dy_next[ch];
            end
            if (en[3]) begin
                d_mag_reg[ch]     <= c_mag_reg[ch];
                d_prod_reg[ch]    <= d_prod_next[ch];
                d_y0_reg[ch]      <= c_y0_reg[ch];
            end
            if (en[4]) begin
                e_mag_reg[ch]     <= d_mag_reg[ch];
                e_curve_reg[ch]   <= e_curve_next[ch];
            end
            if (en[5]) begin
                f_blend_reg[ch]   <= f_blend_next[ch];
            end
            if (en[6]) begin
                g_w_reg[ch]       <= g_w_next[ch];
            end
            if (en[7]) begin
                h_t_reg[ch]       <= h_t_next[ch];
            end
            if (en[8]) begin
                out_reg[ch]       <= out_next[ch];
            end
            // carry the sign down the pipe
            for (int i = 1; i < Stages - 1; i++) begin
                if (en[i]) begin
                    neg_reg[ch][i] <= neg_reg[ch][i-1];
                end
            end
        end
    end

    assign m_aileron_out  = out_reg[0];
    assign m_elevator_out = out_reg[1];
    assign m_rudder_out   = out_reg[2];

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_aileron_out) <= 12'sd1250 && $signed(m_aileron_out) >= -12'sd1250))
        else $error("aileron result outside limit");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&vld_reg)))
        else $error("input stalled while pipeline has a bubble");

    a_zero_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && rate_reg[0] == '0) |-> (m_aileron_out == '0))
        else $error("zero rate gave nonzero aileron result");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: test/dual_rate_expo_curve_unit_check.sv
`timescale 1ns / 100ps

module dual_rate_expo_curve_unit_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [drec_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [drec_pkg::PctW-1:0]           cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [drec_pkg::ValueW-1:0]  s_aileron_in,
    input  logic signed [drec_pkg::ValueW-1:0]  s_elevator_in,
    input  logic signed [drec_pkg::ValueW-1:0]  s_rudder_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [drec_pkg::ValueW-1:0]  m_aileron_out,
    input  logic signed [drec_pkg::ValueW-1:0]  m_elevator_out,
    input  logic signed [drec_pkg::ValueW-1:0]  m_rudder_out,
    output int                                  mismatches,
    output int                                  frames_in,
    output int                                  frames_out
);
    import drec_pkg::*;

    localparam int ReportCap = 40;

    // exponential stick curve, one point every 50 counts of magnitude
    localparam int KneeHeight [0:25] = '{
        0, 2, 4, 7, 10, 14, 20, 26, 33, 43, 54, 68, 84,
        106, 131, 162, 200, 246, 302, 370, 454, 557, 682, 835, 1022, 1250
    };

    typedef struct packed {
        logic [ValueW-1:0] aileron;
        logic [ValueW-1:0] elevator;
        logic [ValueW-1:0] rudder;
    } stick_frame_t;

    logic [PctW-1:0] expo_setting [0:2];
    logic [PctW-1:0] rate_setting [0:2];
    stick_frame_t    shaped_frames [$];

    function automatic logic [ValueW-1:0] shape_stick(input logic signed [ValueW-1:0] stick,
                                                      input logic [PctW-1:0] expo_raw,
                                                      input logic [PctW-1:0] rate_raw);
        int  mag;
        int  seg;
        int  curve;
        int  expo;
        int  rate;
        int  blend;
        bit  neg;
        neg = stick < 0;
        mag = neg ? -int'(stick) : int'(stick);
        if (mag > ValueLimit) mag = ValueLimit;
        seg = mag / SegWidth;
        if (seg >= Segments) seg = Segments - 1;
        curve = (mag - seg * SegWidth) * (KneeHeight[seg + 1] - KneeHeight[seg]) / SegWidth
                + KneeHeight[seg];
        // percents above full scale act as full scale
        expo = (int'(expo_raw) > PctFull) ? PctFull : int'(expo_raw);
        rate = (int'(rate_raw) > PctFull) ? PctFull : int'(rate_raw);
        blend = (expo * curve + (PctFull - expo) * mag) / PctFull;
        if (neg) blend = -blend;
        return ValueW'(blend * rate / PctFull);
    endfunction

    function automatic int field_miss(input string label, input logic [ValueW-1:0] want,
                                      input logic [ValueW-1:0] got, input bit loud);
        if (want === got) return 0;
        if (loud)
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, label, $signed(want), $signed(got));
        return 1;
    endfunction

    always @(posedge aclk) begin
        stick_frame_t want;
        int           bad;
        bit           loud;
        bad  = 0;
        loud = mismatches < ReportCap;
        if (!aresetn) begin
            for (int c = 0; c < ChanCount; c++) begin
                expo_setting[c] <= '0;
                rate_setting[c] <= PctW'(PctFull);
            end
            shaped_frames.delete();
            frames_in  <= 0;
            frames_out <= 0;
            mismatches <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EXPO_AILERON:  expo_setting[0] <= cfg_data;
                    CFG_EXPO_ELEVATOR: expo_setting[1] <= cfg_data;
                    CFG_EXPO_RUDDER:   expo_setting[2] <= cfg_data;
                    CFG_RATE_AILERON:  rate_setting[0] <= cfg_data;
                    CFG_RATE_ELEVATOR: rate_setting[1] <= cfg_data;
                    CFG_RATE_RUDDER:   rate_setting[2] <= cfg_data;
                    default: ;  // drop writes to unmapped indexes
                endcase
            end
            if (s_valid && s_ready) begin
                want.aileron  = shape_stick(s_aileron_in, expo_setting[0], rate_setting[0]);
                want.elevator = shape_stick(s_elevator_in, expo_setting[1], rate_setting[1]);
                want.rudder   = shape_stick(s_rudder_in, expo_setting[2], rate_setting[2]);
                shaped_frames.push_back(want);
                frames_in <= frames_in + 1;
            end
            if (m_valid && m_ready) begin
                if (shaped_frames.size() == 0) begin
                    if (loud)
                        $display("%0t: frame out with none pending, expected nothing, got %0d %0d %0d",
                                 $time, m_aileron_out, m_elevator_out, m_rudder_out);
                    bad = 1;
                end else begin
                    want = shaped_frames.pop_front();
                    bad = field_miss("aileron_out", want.aileron, m_aileron_out, loud)
                        + field_miss("elevator_out", want.elevator, m_elevator_out, loud)
                        + field_miss("rudder_out", want.rudder, m_rudder_out, loud);
                end
                frames_out <= frames_out + 1;
            end
            mismatches <= mismatches + bad;
        end
    end

endmodule

FILE: test/dual_rate_expo_curve_unit_test.sv
`timescale 1ns / 100ps

module dual_rate_expo_curve_unit_test;
    import drec_pkg::*;

    localparam int PhaseFrames    = 135;
    localparam int SinkHoldCycles = 60;
    localparam int SettleCycles   = 20;
    localparam int WatchdogLimit  = 4000;
    localparam logic [CfgIdxW-1:0] CfgSpareLow  = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgSpareHigh = 3'd7;

    localparam int Corner [0:11] = '{0, 1, 49, 50, 51, 625, 1199, 1200, 1249, 1250, 1251, 2047};

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CfgIdxW-1:0]        cfg_index;
    logic [PctW-1:0]           cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [ValueW-1:0]  s_aileron_in;
    logic signed [ValueW-1:0]  s_elevator_in;
    logic signed [ValueW-1:0]  s_rudder_in;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [ValueW-1:0]  m_aileron_out;
    logic signed [ValueW-1:0]  m_elevator_out;
    logic signed [ValueW-1:0]  m_rudder_out;

    int mismatches;
    int frames_in;
    int frames_out;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit sink_hold_req = 1'b0;
    int quiet_cycles  = 0;
    int setups        = 0;

    dual_rate_expo_curve_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_aileron_in  (s_aileron_in),
        .s_elevator_in (s_elevator_in),
        .s_rudder_in   (s_rudder_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_aileron_out (m_aileron_out),
        .m_elevator_out(m_elevator_out),
        .m_rudder_out  (m_rudder_out)
    );

    dual_rate_expo_curve_unit_check check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_aileron_in  (s_aileron_in),
        .s_elevator_in (s_elevator_in),
        .s_rudder_in   (s_rudder_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_aileron_out (m_aileron_out),
        .m_elevator_out(m_elevator_out),
        .m_rudder_out  (m_rudder_out),
        .mismatches    (mismatches),
        .frames_in     (frames_in),
        .frames_out    (frames_out)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("dual_rate_expo_curve_unit_test NOT OK");
            $finish;
        end
    end

    // output side: random back-pressure, or one long hold when asked
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SinkHoldCycles) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge aclk);
            end
        end
    end

    function automatic logic [ValueW-1:0] pick_stick();
        int roll;
        int mag;
        roll = $urandom_range(99);
        if (roll < 45) begin
            mag = int'($urandom_range(2 * ValueLimit)) - ValueLimit;
        end else if (roll < 65) begin
            // land on or next to a segment edge
            mag = int'($urandom_range(Segments)) * SegWidth + int'($urandom_range(2)) - 1;
        end else if (roll < 85) begin
            mag = int'($urandom_range(2047, ValueLimit + 1));
        end else begin
            return ValueW'($urandom);
        end
        if (roll >= 45 && $urandom_range(1)) mag = -mag;
        return ValueW'(mag);
    endfunction

    function automatic logic [PctW-1:0] pick_pct();
        case ($urandom_range(5))
            0:       return '0;
            1:       return PctW'(PctFull);
            2:       return '1;
            default: return PctW'($urandom_range(127));
        endcase
    endfunction

    task automatic send_frame(input logic [ValueW-1:0] ail, input logic [ValueW-1:0] ele,
                              input logic [ValueW-1:0] rud);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_aileron_in  <= ail;
        s_elevator_in <= ele;
        s_rudder_in   <= rud;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every request in flight has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_in != frames_out) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [PctW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic load_setup(input logic [PctW-1:0] ea, input logic [PctW-1:0] ee,
                              input logic [PctW-1:0] er, input logic [PctW-1:0] ra,
                              input logic [PctW-1:0] re, input logic [PctW-1:0] rr);
        drain();
        cfg_we <= 1'b1;
        put_reg(CFG_EXPO_AILERON, ea);
        put_reg(CFG_EXPO_ELEVATOR, ee);
        put_reg(CFG_EXPO_RUDDER, er);
        put_reg(CFG_RATE_AILERON, ra);
        put_reg(CFG_RATE_ELEVATOR, re);
        put_reg(CFG_RATE_RUDDER, rr);
        // unmapped indexes must leave the settings alone
        put_reg(CfgSpareLow, PctW'($urandom));
        put_reg(CfgSpareHigh, PctW'($urandom));
        cfg_we <= 1'b0;
        setups++;
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_EXPO_AILERON;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_aileron_in  <= '0;
        s_elevator_in <= '0;
        s_rudder_in   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners at the reset settings: linear curve, full rate
        for (int i = 0; i < 12; i++)
            send_frame(ValueW'(Corner[i]), ValueW'(-Corner[i]), ValueW'(Corner[11 - i]));

        // full expo, over-range percents, zero and minimal rate
        load_setup(PctW'(PctFull), '1, PctW'(55), '1, '0, PctW'(1));
        for (int i = 0; i < 12; i++)
            send_frame(ValueW'(-Corner[i]), ValueW'(Corner[(i + 4) % 12]),
                       ValueW'(-Corner[11 - i]));
        send_frame(ValueW'(-2048), ValueW'(-2048), ValueW'(-2048));

        for (int phase = 0; phase < 3; phase++) begin
            load_setup(pick_pct(), pick_pct(), pick_pct(), pick_pct(), pick_pct(), pick_pct());
            case (phase)
                0: begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 59;
                end
                1: begin
                    src_idle_pct  = 59;
                    sink_idle_pct = 27;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    // hold the output long enough to back the pipeline up to the input
                    sink_hold_req = 1'b1;
                end
            endcase
            for (int n = 0; n < PhaseFrames; n++)
                send_frame(pick_stick(), pick_stick(), pick_stick());
        end

        drain();
        repeat (SettleCycles) @(posedge aclk);
        $display("Shaped %0d stick frames over %0d register setups, incl. saturated inputs,",
                 frames_out, setups);
        $display("segment edges, over-range percents, unmapped writes and a long output stall.");
        if (mismatches == 0 && frames_in == frames_out) begin
            $display("dual_rate_expo_curve_unit_test OK");
        end else begin
            $display("dual_rate_expo_curve_unit_test NOT OK");
        end
        $finish;
    end

endmodule
